### rtl/core/hbdt_pkg.sv
// hbdt_pkg: shared types, register codes and the gamma threshold table builder
// for the hdr box downscale tonemap block. No dependencies.
`default_nettype none

package hbdt_pkg;

  // configuration register indexes
  localparam logic [1:0] CFG_SRC_WIDTH  = 2'd0;
  localparam logic [1:0] CFG_SRC_HEIGHT = 2'd1;
  localparam logic [1:0] CFG_PREVIEW    = 2'd2;

  localparam int CFG_DATA_W      = 13;
  localparam int PREVIEW_DEFAULT = 512;
  localparam int THR_W           = 17;

  typedef logic [THR_W-1:0] thr_t;
  typedef thr_t thr_tab_t [256];

  // smallest table index i for which byte k is reached:
  // (2k-1)^11 * 2^(5*bits) <= i^5 * 510^11
  function automatic thr_tab_t gamma_thr_tab(input int bits);
    thr_tab_t     tab;
    logic [191:0] base;
    logic [191:0] lhs;
    logic [191:0] prod;
    int           lo;
    int           hi;
    int           mid;
    base = 192'd1;
    for (int i = 0; i < 11; i++) begin
      base = base * 192'd510;
    end
    tab[0] = '0;
    for (int k = 1; k < 256; k++) begin
      lhs = 192'd1;
      for (int i = 0; i < 11; i++) begin
        lhs = lhs * 192'(2 * k - 1);
      end
      lhs = lhs << (5 * bits);
      lo = 0;
      hi = 1 << bits;
      while (lo < hi) begin
        mid = (lo + hi) >> 1;
        prod = base;
        for (int i = 0; i < 5; i++) begin
          prod = prod * 192'(mid);
        end
        if (lhs <= prod) begin
          hi = mid;
        end else begin
          lo = mid + 1;
        end
      end
      tab[k] = THR_W'(lo);
    end
    return tab;
  endfunction

endpackage

`default_nettype wire

### rtl/core/hbdt_ram.sv
// hbdt_ram: generic simple dual port ram, one write port and one read port
// with registered read data. No dependencies.
`default_nettype none

module hbdt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

### rtl/core/hdr_box_downscale_tonemap.sv
// hdr_box_downscale_tonemap: top level of the hdr preview downscaler
// depends on hbdt_pkg and hbdt_ram
//
// Usage:
//   Source pixels enter in raster order on the in channel (valid/stall), one
//   transaction per pixel with frame_start on pixel (0,0). Box sums for two
//   preview rows live in one accumulator ram holding all three channels.
//   Each pixel is accepted and then handled in four read-modify-write slots
//   on the accumulator ram (up to two box columns in two box rows).
//   When a pixel closes a box, the average is tonemapped: setup in S_PREP and
//   S_DINIT, a restoring divider that gives GAMMA_TABLE_BITS+1 quotient bits,
//   an 8 step search of the gamma threshold table and then a load of the
//   output register.
//   The result sits in an output register; new pixels are accepted while it
//   waits. The block holds off the in channel whenever it is not idle or a
//   configuration write is under way, also while a second result waits.
//   Reset clears counters and control; the ram needs no clearing since each
//   box entry is overwritten at the first pixel of its box.
//   A write to one of the three configuration registers restarts the frame at source pixel (0,0).
`default_nettype none

module hdr_box_downscale_tonemap #(
  parameter int MAX_SOURCE_DIM   = 4096,
  parameter int MAX_PREVIEW_DIM  = 512,
  parameter int GAMMA_TABLE_BITS = 12
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,

  input  wire logic        cfg_we_i,
  input  wire logic [1:0]  cfg_idx_i,
  input  wire logic [12:0] cfg_wdata_i,

  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic        frame_start_i,
  input  wire logic [15:0] red_in_i,
  input  wire logic [15:0] green_in_i,
  input  wire logic [15:0] blue_in_i,

  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [8:0]       out_col_o,
  output logic [8:0]       out_row_o,
  output logic [7:0]       red_out_o,
  output logic [7:0]       green_out_o,
  output logic [7:0]       blue_out_o,
  output logic             last_pixel_o
);

  localparam int XW   = $clog2(MAX_SOURCE_DIM);
  localparam int SDW  = $clog2(MAX_SOURCE_DIM + 1);
  localparam int PW   = $clog2(MAX_PREVIEW_DIM);
  localparam int PDW  = $clog2(MAX_PREVIEW_DIM + 1);
  localparam int SUMW = 16 + 2 * XW;
  localparam int CNTW = 2 * XW + 2;
  localparam int QW   = GAMMA_TABLE_BITS + 1;
  localparam int NUMW = SUMW + GAMMA_TABLE_BITS + 2;
  localparam int STW  = $clog2(QW);
  localparam int AW   = PW + 1;
  localparam int DEPTH = 2 ** AW;

  localparam hbdt_pkg::thr_tab_t GAMMA_THR = hbdt_pkg::gamma_thr_tab(GAMMA_TABLE_BITS);

  typedef enum logic [2:0] {
    S_IDLE, S_ACC, S_PREP, S_DINIT, S_DIV, S_GAM, S_OUT
  } state_e;

  typedef logic [SUMW-1:0] sum_t;

  state_e state_q;

  // configuration
  logic [12:0] w_raw_q, h_raw_q;
  logic [9:0]  p_raw_q;
  logic [SDW-1:0] w, h;
  logic [PDW-1:0] p, n, m;
  logic [31:0]    p32;

  // position trackers
  logic [XW-1:0] x_q, y_q, rca_q, rra_q, cls_q, cps_q, rls_q, rps_q;
  logic [PW-1:0] ca_q, ra_q;

  logic          accept, restart;
  logic [XW-1:0] x, y, rca, rra, cls, rls;
  logic [PW-1:0] ca, ra, cb, rb;
  logic [31:0]   cs, rs, cadv, radv;
  logic          c_carry, r_carry, end_c, end_r, top_c, top_r;
  logic [XW-1:0] cls_d, cps_d, rls_d, rps_d;
  logic [XW-1:0] x_d, y_d, rca_d, rra_d;
  logic [PW-1:0] ca_d, ra_d;
  logic [XW:0]   cw, rh;

  // per pixel work registers
  logic [PW-1:0] p_ca_q, p_cb_q, p_ecol_q, p_erow_q;
  logic          p_rap_q, p_rbp_q, p_dc_q, p_dr_q, p_topc_q, p_topr_q;
  logic          p_ecs_q, p_ers_q, p_emit_q, p_last_q;
  logic [15:0]   p_r_q, p_g_q, p_b_q;
  logic [XW:0]   p_cw_q, p_rh_q;
  logic [CNTW-1:0] cnt_q;
  logic [1:0]    j_q;

  // ram access
  logic          rsel, csel, ent_vld, ent_ovw, ent_end;
  logic [AW-1:0] rd_addr;
  logic          wr_vld_q, wr_ovw_q, wr_end_q;
  logic [AW-1:0] wr_addr_q;
  logic [3*SUMW-1:0] ram_rdata, ram_wdata;
  sum_t          rd_r, rd_g, rd_b;
  sum_t          cap_q [3];

  // divide and gamma lanes
  logic [NUMW-1:0] rem_q [3];
  logic [NUMW-1:0] dsh_q [3];
  logic [QW-1:0]   quo_q [3];
  logic [7:0]      k_q [3];
  logic [STW-1:0]  stp_q;
  logic [2:0]      gb_q;
  logic            out_load;

  // ---------------------------------------------------------------- config
  always_comb begin
    if (w_raw_q == '0) begin
      w = SDW'(1);
    end else if (32'(w_raw_q) > 32'(MAX_SOURCE_DIM)) begin
      w = SDW'(MAX_SOURCE_DIM);
    end else begin
      w = SDW'(w_raw_q);
    end
    if (h_raw_q == '0) begin
      h = SDW'(1);
    end else if (32'(h_raw_q) > 32'(MAX_SOURCE_DIM)) begin
      h = SDW'(MAX_SOURCE_DIM);
    end else begin
      h = SDW'(h_raw_q);
    end
    p32 = (p_raw_q == '0) ? 32'(hbdt_pkg::PREVIEW_DEFAULT) : 32'(p_raw_q);
    if (p32 > 32'(MAX_PREVIEW_DIM)) begin
      p32 = 32'(MAX_PREVIEW_DIM);
    end
    p = PDW'(p32);
    n = (32'(w) < 32'(p)) ? PDW'(w) : p;
    m = (32'(h) < 32'(p)) ? PDW'(h) : p;
  end

  // ---------------------------------------------------------------- position
  assign accept  = in_valid_i && !in_stall_o;
  assign restart = frame_start_i || (32'(x_q) >= 32'(w)) || (32'(y_q) >= 32'(h));

  always_comb begin
    x   = restart ? '0 : x_q;
    y   = restart ? '0 : y_q;
    ca  = restart ? '0 : ca_q;
    rca = restart ? '0 : rca_q;
    ra  = restart ? '0 : ra_q;
    rra = restart ? '0 : rra_q;
    cls = restart ? '0 : cls_q;
    rls = restart ? '0 : rls_q;

    // last box column holding x and whether x closes it
    cs      = 32'(rca) + 32'(n) - 32'd1;
    c_carry = cs >= 32'(w);
    cb      = ca + PW'(c_carry);
    if (c_carry) begin
      cs = cs - 32'(w);
    end
    end_c = cs == 32'(w) - 32'd1;
    top_c = rca == '0;

    rs      = 32'(rra) + 32'(m) - 32'd1;
    r_carry = rs >= 32'(h);
    rb      = ra + PW'(r_carry);
    if (r_carry) begin
      rs = rs - 32'(h);
    end
    end_r = rs == 32'(h) - 32'd1;
    top_r = rra == '0;

    // start columns of the two newest boxes
    cps_d = restart ? '0 : cps_q;
    cls_d = cls;
    if (top_c && c_carry) begin
      cps_d = x;
      cls_d = x;
    end else if (top_c || c_carry) begin
      cps_d = cls;
      cls_d = x;
    end
    rps_d = restart ? '0 : rps_q;
    rls_d = rls;
    if (x == '0) begin
      if (top_r && r_carry) begin
        rps_d = y;
        rls_d = y;
      end else if (top_r || r_carry) begin
        rps_d = rls;
        rls_d = y;
      end
    end
    cw = end_c ? ({1'b0, x} - {1'b0, cls_d} + 1'b1) : ({1'b0, x} - {1'b0, cps_d} + 1'b1);
    rh = end_r ? ({1'b0, y} - {1'b0, rls_d} + 1'b1) : ({1'b0, y} - {1'b0, rps_d} + 1'b1);

    // advance to the next source pixel
    x_d   = x + 1'b1;
    y_d   = y;
    ca_d  = ca;
    rca_d = rca;
    ra_d  = ra;
    rra_d = rra;
    cadv  = 32'(rca) + 32'(n);
    radv  = 32'(rra) + 32'(m);
    if (32'(x) + 32'd1 >= 32'(w)) begin
      x_d   = '0;
      ca_d  = '0;
      rca_d = '0;
      if (32'(y) + 32'd1 >= 32'(h)) begin
        y_d   = '0;
        ra_d  = '0;
        rra_d = '0;
      end else begin
        y_d = y + 1'b1;
        if (radv >= 32'(h)) begin
          rra_d = XW'(radv - 32'(h));
          ra_d  = ra + 1'b1;
        end else begin
          rra_d = XW'(radv);
        end
      end
    end else if (cadv >= 32'(w)) begin
      rca_d = XW'(cadv - 32'(w));
      ca_d  = ca + 1'b1;
    end else begin
      rca_d = XW'(cadv);
    end
  end

  // ---------------------------------------------------------------- ram slots
  always_comb begin
    rsel    = j_q[1];
    csel    = j_q[0];
    ent_vld = (!rsel || p_dr_q) && (!csel || p_dc_q);
    ent_ovw = (rsel || p_topr_q) && (csel || p_topc_q);
    ent_end = (csel == (p_ecs_q && p_dc_q)) && (rsel == (p_ers_q && p_dr_q));
    rd_addr = {rsel ? p_rbp_q : p_rap_q, csel ? p_cb_q : p_ca_q};
  end

  assign rd_r = ram_rdata[3*SUMW-1:2*SUMW];
  assign rd_g = ram_rdata[2*SUMW-1:SUMW];
  assign rd_b = ram_rdata[SUMW-1:0];

  always_comb begin
    if (wr_ovw_q) begin
      ram_wdata = {SUMW'(p_r_q), SUMW'(p_g_q), SUMW'(p_b_q)};
    end else begin
      ram_wdata = {rd_r + SUMW'(p_r_q), rd_g + SUMW'(p_g_q), rd_b + SUMW'(p_b_q)};
    end
  end

  hbdt_ram #(
    .WIDTH (3 * SUMW),
    .DEPTH (DEPTH)
  ) u_sums (
    .clk_i   (clk_i),
    .we_i    (wr_vld_q),
    .waddr_i (wr_addr_q),
    .wdata_i (ram_wdata),
    .raddr_i (rd_addr),
    .rdata_o (ram_rdata)
  );

  assign out_load = (state_q == S_OUT) && (!out_valid_o || !out_stall_i);

  // ---------------------------------------------------------------- control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      w_raw_q  <= 13'd1;
      h_raw_q  <= 13'd1;
      p_raw_q  <= '0;
      x_q      <= '0;
      y_q      <= '0;
      ca_q     <= '0;
      rca_q    <= '0;
      ra_q     <= '0;
      rra_q    <= '0;
      cls_q    <= '0;
      cps_q    <= '0;
      rls_q    <= '0;
      rps_q    <= '0;
      j_q      <= '0;
      wr_vld_q <= 1'b0;
      stp_q    <= '0;
      gb_q     <= '0;
      out_valid_o  <= 1'b0;
      out_col_o    <= '0;
      out_row_o    <= '0;
      red_out_o    <= '0;
      green_out_o  <= '0;
      blue_out_o   <= '0;
      last_pixel_o <= 1'b0;
    end else begin
      wr_vld_q <= (state_q == S_ACC) && ent_vld;
      if (out_load) begin
        out_valid_o <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_o <= 1'b0;
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          hbdt_pkg::CFG_SRC_WIDTH:  w_raw_q <= cfg_wdata_i;
          hbdt_pkg::CFG_SRC_HEIGHT: h_raw_q <= cfg_wdata_i;
          hbdt_pkg::CFG_PREVIEW:    p_raw_q <= cfg_wdata_i[9:0];
          default: ;
        endcase
        if (cfg_idx_i == hbdt_pkg::CFG_SRC_WIDTH || cfg_idx_i == hbdt_pkg::CFG_SRC_HEIGHT ||
            cfg_idx_i == hbdt_pkg::CFG_PREVIEW) begin
          x_q   <= '0;
          y_q   <= '0;
          ca_q  <= '0;
          rca_q <= '0;
          ra_q  <= '0;
          rra_q <= '0;
        end
      end else if (accept) begin
        x_q   <= x_d;
        y_q   <= y_d;
        ca_q  <= ca_d;
        rca_q <= rca_d;
        ra_q  <= ra_d;
        rra_q <= rra_d;
        cls_q <= cls_d;
        cps_q <= cps_d;
        rls_q <= rls_d;
        rps_q <= rps_d;
      end
      case (state_q)
        S_IDLE: begin
          if (accept && !cfg_we_i) begin
            j_q     <= '0;
            state_q <= S_ACC;
          end
        end
        S_ACC: begin
          j_q <= j_q + 1'b1;
          if (j_q == 2'd3) begin
            state_q <= p_emit_q ? S_PREP : S_IDLE;
          end
        end
        S_PREP: begin
          state_q <= S_DINIT;
        end
        S_DINIT: begin
          stp_q   <= STW'(QW - 1);
          state_q <= S_DIV;
        end
        S_DIV: begin
          stp_q <= stp_q - 1'b1;
          if (stp_q == '0) begin
            gb_q    <= 3'd7;
            state_q <= S_GAM;
          end
        end
        S_GAM: begin
          gb_q <= gb_q - 1'b1;
          if (gb_q == '0) begin
            state_q <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_load) begin
            out_col_o    <= 9'(p_ecol_q);
            out_row_o    <= 9'(p_erow_q);
            red_out_o    <= k_q[0];
            green_out_o  <= k_q[1];
            blue_out_o   <= k_q[2];
            last_pixel_o <= p_last_q;
            state_q      <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // ---------------------------------------------------------------- datapath
  always_ff @(posedge clk_i) begin
    if (accept && !cfg_we_i) begin
      p_ca_q   <= ca;
      p_cb_q   <= cb;
      p_rap_q  <= ra[0];
      p_rbp_q  <= rb[0];
      p_dc_q   <= c_carry;
      p_dr_q   <= r_carry;
      p_topc_q <= top_c;
      p_topr_q <= top_r;
      p_ecs_q  <= end_c;
      p_ers_q  <= end_r;
      p_ecol_q <= end_c ? cb : ca;
      p_erow_q <= end_r ? rb : ra;
      p_emit_q <= (c_carry || end_c) && (r_carry || end_r);
      p_last_q <= (32'(end_c ? cb : ca) == 32'(n) - 32'd1) &&
                  (32'(end_r ? rb : ra) == 32'(m) - 32'd1);
      p_r_q    <= red_in_i;
      p_g_q    <= green_in_i;
      p_b_q    <= blue_in_i;
      p_cw_q   <= cw;
      p_rh_q   <= rh;
    end
    if (state_q == S_ACC) begin
      cnt_q     <= CNTW'(p_cw_q) * CNTW'(p_rh_q);
      wr_addr_q <= rd_addr;
      wr_ovw_q  <= ent_ovw;
      wr_end_q  <= ent_end;
    end
    if (wr_vld_q && wr_end_q) begin
      cap_q[0] <= ram_wdata[3*SUMW-1:2*SUMW];
      cap_q[1] <= ram_wdata[2*SUMW-1:SUMW];
      cap_q[2] <= ram_wdata[SUMW-1:0];
    end
    for (int c = 0; c < 3; c++) begin
      case (state_q)
        S_DINIT: begin
          // den = S + 256*count, quotient = round(S * 2^B / den)
          rem_q[c] <= (NUMW'(cap_q[c]) << (GAMMA_TABLE_BITS + 1)) + NUMW'(cap_q[c]) +
                      (NUMW'(cnt_q) << 8);
          dsh_q[c] <= (NUMW'(cap_q[c]) + (NUMW'(cnt_q) << 8)) << QW;
          quo_q[c] <= '0;
          k_q[c]   <= '0;
        end
        S_DIV: begin
          if (rem_q[c] >= dsh_q[c]) begin
            rem_q[c] <= rem_q[c] - dsh_q[c];
            quo_q[c] <= {quo_q[c][QW-2:0], 1'b1};
          end else begin
            quo_q[c] <= {quo_q[c][QW-2:0], 1'b0};
          end
          dsh_q[c] <= dsh_q[c] >> 1;
        end
        S_GAM: begin
          if (GAMMA_THR[k_q[c] | (8'd1 << gb_q)] <= hbdt_pkg::THR_W'(quo_q[c])) begin
            k_q[c] <= k_q[c] | (8'd1 << gb_q);
          end
        end
        default: ;
      endcase
    end
  end

  // a register write takes the cycle, so no pixel is taken alongside it
  assign in_stall_o = (state_q != S_IDLE) || cfg_we_i;

  // ---------------------------------------------------------------- checks
  a_no_rmw_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_ACC && ent_vld && wr_vld_q) |-> (wr_addr_q != rd_addr))
    else $error("accumulator read overlaps pending write of same entry");

  a_index_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_GAM) |-> (quo_q[0] <= (QW'(1) << GAMMA_TABLE_BITS)))
    else $error("tone index beyond table range");

  a_out_from_tone: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state_q == S_OUT))
    else $error("output loaded outside of output state");

endmodule

`default_nettype wire
